### hdl/mfusp_pkg.sv
// shared types, constants and tables of the multi-frame serial stream parser
package mfusp_pkg;

  // frame markers
  localparam logic [7:0] SYNC_SENSOR_A = 8'hAA;
  localparam logic [7:0] SYNC_SENSOR_B = 8'h55;
  localparam logic [7:0] SYNC_VOICE_A  = 8'hA5;
  localparam logic [7:0] SYNC_VOICE_B  = 8'h5A;
  localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_CR       = 8'h0D;

  // sensor frame layout
  localparam int SENSOR_LEN     = 34;
  localparam int STORE_WORDS    = 16;
  localparam int STORE_LAST_IDX = 30;
  localparam int FLD_WIDE_CNT   = 14;
  localparam int FLD_FLAG_A     = 14;
  localparam int FLD_FLAG_B     = 15;
  localparam int FLD_LAST       = 16;

  // voice frame
  localparam int VOICE_MAX_BYTES = 60;
  localparam int VHDR_LAST       = 2;

  // text lines
  localparam int TEXT_LINE_MAX_DEF = 128;
  localparam int START_CMD_LEN     = 11;
  localparam int END_CMD_LEN       = 9;
  localparam int ECHO_LAST         = 9;
  localparam int CALL_FIELD_IDX    = 16;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HOST  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_CALL  = 2'd2
  } kind_t;

  // result source select
  typedef enum logic [2:0] {
    SEL_SENSOR = 3'd0,
    SEL_VHDR   = 3'd1,
    SEL_BYTE   = 3'd2,
    SEL_CALL   = 3'd3,
    SEL_ECHO   = 3'd4
  } emit_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic      accept;
    logic      text_start;
    logic      sync_ok;
    logic      body_byte;
    logic      body_end;
    logic      vlen_load;
    logic      vbody_byte;
    logic      text_byte;
    logic      text_end;
    logic      call_set;
    logic      call_val;
    logic      emit_clr;
    logic      emit_step;
    logic      emit_load;
    emit_sel_t emit_sel;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_sensor_a;
    logic is_sensor_b;
    logic is_voice_a;
    logic is_voice_b;
    logic is_dollar;
    logic is_eol;
    logic vlen_ok;
    logic body_end;
    logic check_ok;
    logic start_match;
    logic end_match;
    logic voice_done;
    logic emit_end;
    logic out_free;
  } stat_t;

  // characters of the start command line
  function automatic logic [7:0] start_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h24;
      4'd1:    c = 8'h43;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h4C;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h5F;
      4'd6:    c = 8'h53;
      4'd7:    c = 8'h54;
      4'd8:    c = 8'h41;
      4'd9:    c = 8'h52;
      4'd10:   c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // characters of the end command line, then a line feed
  function automatic logic [7:0] end_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h24;
      4'd1:    c = 8'h43;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h4C;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h5F;
      4'd6:    c = 8'h45;
      4'd7:    c = 8'h4E;
      4'd8:    c = 8'h44;
      4'd9:    c = 8'h0A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hdl/mfusp_in_if.sv
// input word channel: one received byte per word
interface mfusp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hdl/mfusp_out_if.sv
// result word channel: host-link bytes, sensor fields and call mode changes
interface mfusp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] data;
  logic [4:0]  field_index;
  logic        last;

  modport source (output valid, output kind, output data, output field_index, output last,
                  input ready);
  modport sink   (input valid, input kind, input data, input field_index, input last,
                  output ready);
endinterface

### hdl/multi_frame_uart_stream_parser.sv
// top level of the multi-frame serial stream parser
//
// in_ch carries one received byte per word; out_ch carries result words with
// kind (host-link byte, sensor field, call mode change), data, field_index
// and last, which marks the final word caused by one input byte.
// Bytes that cause no result are taken without waiting: in_ch.ready is high
// in every parse state. A voice body byte is accepted, then loaded into the
// output register. A voice length byte gives three header words. A good
// sensor checksum byte starts a 17-word burst; each word is first read from
// the single registered read port of the frame store, then loaded. A call
// line end gives one word, or eleven words for the end command.
// While a burst is produced in_ch.ready is low; when out_ch.ready is low the
// output register holds its word and the burst waits, and the next input
// byte can still be taken while the last word of a burst waits.
// Reset (rst_n low, synchronous) returns to idle, clears counters and call
// mode and empties the output register; no clearing pass is needed.
module multi_frame_uart_stream_parser #(
  parameter int TEXT_LINE_MAX = mfusp_pkg::TEXT_LINE_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mfusp_in_if.sink     in_ch,
  mfusp_out_if.source  out_ch
);

  mfusp_pkg::cmd_t  cmd;
  mfusp_pkg::stat_t stat;
  logic             in_ready;

  // controller
  mfusp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  mfusp_dp #(
    .TEXT_LINE_MAX (TEXT_LINE_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .rx_byte         (in_ch.rx_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_data        (out_ch.data),
    .out_field_index (out_ch.field_index),
    .out_last        (out_ch.last)
  );

  assign in_ch.ready = in_ready;

endmodule

### hdl/mfusp_dp.sv
// datapath: byte capture, frame store, counters, match flags and output register
module mfusp_dp #(
  parameter int TEXT_LINE_MAX = mfusp_pkg::TEXT_LINE_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         rx_byte,
  input  mfusp_pkg::cmd_t    cmd,
  output mfusp_pkg::stat_t   stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [15:0]        out_data,
  output logic [4:0]         out_field_index,
  output logic               out_last
);

  localparam int TLW = $clog2(TEXT_LINE_MAX);

  logic [7:0]     byte_r;
  logic [7:0]     hold_r;
  logic [5:0]     frame_count_r;
  logic [7:0]     running_check_r;
  logic [5:0]     voice_length_r;
  logic [5:0]     voice_count_r;
  logic [TLW-1:0] text_length_r;
  logic           start_alive_r;
  logic           end_alive_r;
  logic           call_mode_r;
  logic [4:0]     emit_idx_r;
  logic [15:0]    mem [mfusp_pkg::STORE_WORDS];
  logic [15:0]    rd_data_r;
  logic [3:0]     rd_addr;
  logic [4:0]     store_idx;
  logic           text_room;

  logic           out_valid_r;
  logic [1:0]     out_kind_r;
  logic [15:0]    out_data_r;
  logic [4:0]     out_idx_r;
  logic           out_last_r;

  logic [1:0]     item_kind;
  logic [15:0]    item_data;
  logic [4:0]     item_idx;
  logic           item_last;
  logic           item_end;

  assign store_idx = 5'(frame_count_r - 6'd2);
  assign text_room = text_length_r < TLW'(TEXT_LINE_MAX - 1);

  // status toward the controller
  always_comb begin
    stat.is_sensor_a = rx_byte == mfusp_pkg::SYNC_SENSOR_A;
    stat.is_sensor_b = rx_byte == mfusp_pkg::SYNC_SENSOR_B;
    stat.is_voice_a  = rx_byte == mfusp_pkg::SYNC_VOICE_A;
    stat.is_voice_b  = rx_byte == mfusp_pkg::SYNC_VOICE_B;
    stat.is_dollar   = rx_byte == mfusp_pkg::CHAR_DOLLAR;
    stat.is_eol      = (rx_byte == mfusp_pkg::CHAR_LF) || (rx_byte == mfusp_pkg::CHAR_CR);
    stat.vlen_ok     = (rx_byte != 8'd0) && (rx_byte <= 8'(mfusp_pkg::VOICE_MAX_BYTES));
    stat.body_end    = frame_count_r == 6'(mfusp_pkg::SENSOR_LEN - 1);
    stat.check_ok    = running_check_r == rx_byte;
    stat.start_match = start_alive_r && (text_length_r == TLW'(mfusp_pkg::START_CMD_LEN));
    stat.end_match   = end_alive_r && (text_length_r == TLW'(mfusp_pkg::END_CMD_LEN));
    stat.voice_done  = voice_count_r >= voice_length_r;
    stat.emit_end    = item_end;
    stat.out_free    = !out_valid_r || out_ready;
  end

  // parse counters and match tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r   <= '0;
      running_check_r <= '0;
      voice_length_r  <= '0;
      voice_count_r   <= '0;
      text_length_r   <= '0;
      start_alive_r   <= 1'b1;
      end_alive_r     <= 1'b1;
      call_mode_r     <= 1'b0;
    end else begin
      if (cmd.sync_ok) begin
        frame_count_r   <= 6'd2;
        running_check_r <= '0;
      end
      if (cmd.body_byte) begin
        running_check_r <= running_check_r ^ rx_byte;
        frame_count_r   <= frame_count_r + 6'd1;
      end
      if (cmd.body_end) begin
        frame_count_r <= '0;
      end
      if (cmd.vlen_load) begin
        voice_count_r  <= '0;
        voice_length_r <= stat.vlen_ok ? rx_byte[5:0] : 6'd0;
      end
      if (cmd.vbody_byte) begin
        voice_count_r <= voice_count_r + 6'd1;
      end
      if (cmd.text_start) begin
        text_length_r <= TLW'(1);
        start_alive_r <= 1'b1;
        end_alive_r   <= 1'b1;
      end
      if (cmd.text_byte && text_room) begin
        if (!((text_length_r < TLW'(mfusp_pkg::START_CMD_LEN)) &&
              (mfusp_pkg::start_char(text_length_r[3:0]) == rx_byte))) begin
          start_alive_r <= 1'b0;
        end
        if (!((text_length_r < TLW'(mfusp_pkg::END_CMD_LEN)) &&
              (mfusp_pkg::end_char(text_length_r[3:0]) == rx_byte))) begin
          end_alive_r <= 1'b0;
        end
        text_length_r <= text_length_r + TLW'(1);
      end
      if (cmd.text_end) begin
        text_length_r <= '0;
      end
      if (cmd.call_set) begin
        call_mode_r <= cmd.call_val;
      end
    end
  end

  // byte capture and pairing of body bytes into words
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= rx_byte;
    end
    if (cmd.body_byte && !store_idx[0]) begin
      hold_r <= rx_byte;
    end
  end

  // frame store: big-endian word pairs of body bytes, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.body_byte) begin
      if (store_idx[0]) begin
        mem[store_idx[4:1]] <= {hold_r, rx_byte};
      end else if (store_idx == 5'(mfusp_pkg::STORE_LAST_IDX)) begin
        mem[store_idx[4:1]] <= {rx_byte, 8'h00};
      end
    end
    rd_data_r <= mem[rd_addr];
  end

  // both flag fields sit in the same word
  always_comb begin
    if (emit_idx_r >= 5'(mfusp_pkg::FLD_FLAG_B)) begin
      rd_addr = 4'(emit_idx_r - 5'd1);
    end else begin
      rd_addr = emit_idx_r[3:0];
    end
  end

  // result counter within a burst
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_clr) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_step) begin
      emit_idx_r <= emit_idx_r + 5'd1;
    end
  end

  // result word assembly
  always_comb begin
    item_kind = mfusp_pkg::KIND_HOST;
    item_data = '0;
    item_idx  = '0;
    item_last = 1'b1;
    item_end  = 1'b1;
    case (cmd.emit_sel)
      mfusp_pkg::SEL_SENSOR: begin
        item_kind = mfusp_pkg::KIND_FIELD;
        item_idx  = emit_idx_r;
        item_end  = emit_idx_r == 5'(mfusp_pkg::FLD_LAST);
        item_last = item_end;
        if (emit_idx_r < 5'(mfusp_pkg::FLD_WIDE_CNT)) begin
          item_data = rd_data_r;
        end else if (emit_idx_r == 5'(mfusp_pkg::FLD_FLAG_B)) begin
          item_data = {8'h00, rd_data_r[7:0]};
        end else begin
          item_data = {8'h00, rd_data_r[15:8]};
        end
      end
      mfusp_pkg::SEL_VHDR: begin
        item_end  = emit_idx_r == 5'(mfusp_pkg::VHDR_LAST);
        item_last = item_end;
        if (emit_idx_r == 5'd0) begin
          item_data = {8'h00, mfusp_pkg::SYNC_VOICE_A};
        end else if (emit_idx_r == 5'd1) begin
          item_data = {8'h00, mfusp_pkg::SYNC_VOICE_B};
        end else begin
          item_data = {8'h00, byte_r};
        end
      end
      mfusp_pkg::SEL_BYTE: begin
        item_data = {8'h00, byte_r};
      end
      mfusp_pkg::SEL_CALL: begin
        item_kind = mfusp_pkg::KIND_CALL;
        item_idx  = 5'(mfusp_pkg::CALL_FIELD_IDX);
        item_data = {15'd0, call_mode_r};
        // clearing is followed by the echo, so it is not the final word
        item_last = call_mode_r;
      end
      mfusp_pkg::SEL_ECHO: begin
        item_end  = emit_idx_r == 5'(mfusp_pkg::ECHO_LAST);
        item_last = item_end;
        item_data = {8'h00, mfusp_pkg::end_char(emit_idx_r[3:0])};
      end
      default: begin
        item_end = 1'b1;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_kind_r <= item_kind;
      out_data_r <= item_data;
      out_idx_r  <= item_idx;
      out_last_r <= item_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_data        = out_data_r;
  assign out_field_index = out_idx_r;
  assign out_last        = out_last_r;

`ifndef NO_ASSERTIONS
  // a word is never loaded over one that is still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending word");

  // body bytes only land in the store positions of bytes 2 to 32
  a_body_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.body_byte |-> (frame_count_r >= 6'd2) &&
                      (frame_count_r < 6'(mfusp_pkg::SENSOR_LEN - 1)))
    else $error("sensor body byte outside frame range");

  // voice body bytes only arrive while the announced length is not used up
  a_voice_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vbody_byte |-> (voice_length_r != 6'd0) && (voice_count_r < voice_length_r))
    else $error("voice body byte beyond announced length");
`endif

endmodule

### hdl/mfusp_ctrl.sv
// controller: parse phase tracking and sequencing of result bursts
module mfusp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mfusp_pkg::stat_t stat,
  output mfusp_pkg::cmd_t  cmd
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_SYNC2    = 14'b00000000000010,
    ST_BODY     = 14'b00000000000100,
    ST_VSYNC2   = 14'b00000000001000,
    ST_VLEN     = 14'b00000000010000,
    ST_VBODY    = 14'b00000000100000,
    ST_TEXT     = 14'b00000001000000,
    ST_SREAD    = 14'b00000010000000,
    ST_SPUT     = 14'b00000100000000,
    ST_VHDR     = 14'b00001000000000,
    ST_VBYTE    = 14'b00010000000000,
    ST_CALL_ON  = 14'b00100000000000,
    ST_CALL_OFF = 14'b01000000000000,
    ST_ECHO     = 14'b10000000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   acc;

  // bytes are taken only in the parse states
  always_comb begin
    in_ready = (state_r == ST_IDLE) || (state_r == ST_SYNC2) || (state_r == ST_BODY) ||
               (state_r == ST_VSYNC2) || (state_r == ST_VLEN) || (state_r == ST_VBODY) ||
               (state_r == ST_TEXT);
  end

  assign acc = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.emit_sel = mfusp_pkg::SEL_BYTE;
    cmd.accept   = acc;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (stat.is_sensor_a) begin
            state_nxt = ST_SYNC2;
          end else if (stat.is_voice_a) begin
            state_nxt = ST_VSYNC2;
          end else if (stat.is_dollar) begin
            cmd.text_start = 1'b1;
            state_nxt      = ST_TEXT;
          end
        end
      end
      ST_SYNC2: begin
        if (acc) begin
          if (stat.is_sensor_b) begin
            cmd.sync_ok = 1'b1;
            state_nxt   = ST_BODY;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BODY: begin
        if (acc) begin
          if (!stat.body_end) begin
            cmd.body_byte = 1'b1;
          end else begin
            cmd.body_end = 1'b1;
            if (stat.check_ok) begin
              cmd.emit_clr = 1'b1;
              state_nxt    = ST_SREAD;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_VSYNC2: begin
        if (acc) begin
          state_nxt = stat.is_voice_b ? ST_VLEN : ST_IDLE;
        end
      end
      ST_VLEN: begin
        if (acc) begin
          cmd.vlen_load = 1'b1;
          if (stat.vlen_ok) begin
            cmd.emit_clr = 1'b1;
            state_nxt    = ST_VHDR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_VBODY: begin
        if (acc) begin
          cmd.vbody_byte = 1'b1;
          state_nxt      = ST_VBYTE;
        end
      end
      ST_TEXT: begin
        if (acc) begin
          if (stat.is_eol) begin
            cmd.text_end = 1'b1;
            if (stat.start_match) begin
              cmd.call_set = 1'b1;
              cmd.call_val = 1'b1;
              state_nxt    = ST_CALL_ON;
            end else if (stat.end_match) begin
              cmd.call_set = 1'b1;
              cmd.call_val = 1'b0;
              state_nxt    = ST_CALL_OFF;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            cmd.text_byte = 1'b1;
          end
        end
      end
      // the frame store read is registered; the field is loaded from it in ST_SPUT
      ST_SREAD: begin
        cmd.emit_sel = mfusp_pkg::SEL_SENSOR;
        state_nxt    = ST_SPUT;
      end
      ST_SPUT: begin
        cmd.emit_sel = mfusp_pkg::SEL_SENSOR;
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_step = 1'b1;
          state_nxt     = stat.emit_end ? ST_IDLE : ST_SREAD;
        end
      end
      ST_VHDR: begin
        cmd.emit_sel = mfusp_pkg::SEL_VHDR;
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_step = 1'b1;
          if (stat.emit_end) begin
            state_nxt = ST_VBODY;
          end
        end
      end
      ST_VBYTE: begin
        cmd.emit_sel = mfusp_pkg::SEL_BYTE;
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = stat.voice_done ? ST_IDLE : ST_VBODY;
        end
      end
      ST_CALL_ON: begin
        cmd.emit_sel = mfusp_pkg::SEL_CALL;
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_CALL_OFF: begin
        cmd.emit_sel = mfusp_pkg::SEL_CALL;
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_clr  = 1'b1;
          state_nxt     = ST_ECHO;
        end
      end
      ST_ECHO: begin
        cmd.emit_sel = mfusp_pkg::SEL_ECHO;
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_step = 1'b1;
          if (stat.emit_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // no input byte is taken while a burst is being produced
  a_load_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> !in_ready)
    else $error("result load while accepting input");

  // the final sensor field closes the frame and parsing resumes
  a_sensor_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPUT && cmd.emit_load && stat.emit_end) |=> state_r == ST_IDLE)
    else $error("sensor burst did not return to idle");
`endif

endmodule

### test/mfusp_parse_checker.sv
// result checker for the multi-frame serial stream parser: predicts and compares result words
module mfusp_parse_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [15:0] out_data,
  input  logic [4:0]  out_field_index,
  input  logic        out_last,
  output int          result_errors,
  output int          results_pending,
  output int          results_checked
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SENSOR_SYNC,
    ST_SENSOR_BODY,
    ST_VOICE_SYNC,
    ST_VOICE_LEN,
    ST_VOICE_BODY,
    ST_TEXT
  } parse_state_t;

  typedef struct packed {
    mfusp_pkg::kind_t kind;
    logic [15:0]      data;
    logic [4:0]       field_index;
    logic             last;
  } result_word_t;

  localparam logic [87:0] START_CMD = {"$CALL", "_START"};
  localparam logic [71:0] END_CMD   = {"$CALL", "_END"};
  localparam int          LINE_KEEP = mfusp_pkg::TEXT_LINE_MAX_DEF - 1;

  // predicted parser state
  parse_state_t state;
  logic [5:0]   sensor_pos;
  logic [7:0]   sensor_bytes [31];
  logic [7:0]   sensor_xor;
  logic [5:0]   voice_len;
  logic [5:0]   voice_seen;
  logic [6:0]   line_len;
  logic         start_alive;
  logic         end_alive;
  logic         call_active;

  result_word_t expected_words [$];
  result_word_t seen_word;
  int           error_count;
  int           checked_count;

  task automatic queue_word(input mfusp_pkg::kind_t k, input logic [15:0] d,
                            input logic [4:0] idx);
    result_word_t w;
    w.kind        = k;
    w.data        = d;
    w.field_index = idx;
    w.last        = 1'b0;
    expected_words.push_back(w);
  endtask

  // advance the predicted parser by one received byte
  task automatic decode_byte(input logic [7:0] b);
    int           before_count;
    int           i;
    result_word_t w;
    before_count = expected_words.size();
    case (state)
      ST_IDLE: begin
        if (b == mfusp_pkg::SYNC_SENSOR_A) begin
          state = ST_SENSOR_SYNC;
        end else if (b == mfusp_pkg::SYNC_VOICE_A) begin
          state = ST_VOICE_SYNC;
        end else if (b == mfusp_pkg::CHAR_DOLLAR) begin
          line_len    = 7'd1;
          start_alive = 1'b1;
          end_alive   = 1'b1;
          state       = ST_TEXT;
        end
      end
      ST_SENSOR_SYNC: begin
        if (b == mfusp_pkg::SYNC_SENSOR_B) begin
          sensor_pos = 6'd2;
          sensor_xor = 8'h00;
          state      = ST_SENSOR_BODY;
        end else begin
          state = ST_IDLE;
        end
      end
      ST_SENSOR_BODY: begin
        if (sensor_pos < mfusp_pkg::SENSOR_LEN - 1) begin
          sensor_bytes[sensor_pos - 2] = b;
          sensor_xor = sensor_xor ^ b;
          sensor_pos = sensor_pos + 6'd1;
        end else begin
          // good check: fourteen wide fields, two flags, emergency byte
          if (sensor_xor == b) begin
            for (i = 0; i < mfusp_pkg::FLD_WIDE_CNT; i++)
              queue_word(mfusp_pkg::KIND_FIELD, {sensor_bytes[2*i], sensor_bytes[2*i+1]},
                         i[4:0]);
            queue_word(mfusp_pkg::KIND_FIELD, {8'h00, sensor_bytes[28]},
                       5'(mfusp_pkg::FLD_FLAG_A));
            queue_word(mfusp_pkg::KIND_FIELD, {8'h00, sensor_bytes[29]},
                       5'(mfusp_pkg::FLD_FLAG_B));
            queue_word(mfusp_pkg::KIND_FIELD, {8'h00, sensor_bytes[30]},
                       5'(mfusp_pkg::FLD_LAST));
          end
          sensor_pos = 6'd0;
          state      = ST_IDLE;
        end
      end
      ST_VOICE_SYNC: begin
        state = (b == mfusp_pkg::SYNC_VOICE_B) ? ST_VOICE_LEN : ST_IDLE;
      end
      ST_VOICE_LEN: begin
        voice_seen = 6'd0;
        if (b >= 1 && b <= mfusp_pkg::VOICE_MAX_BYTES) begin
          voice_len = b[5:0];
          queue_word(mfusp_pkg::KIND_HOST, {8'h00, mfusp_pkg::SYNC_VOICE_A}, 5'd0);
          queue_word(mfusp_pkg::KIND_HOST, {8'h00, mfusp_pkg::SYNC_VOICE_B}, 5'd0);
          queue_word(mfusp_pkg::KIND_HOST, {8'h00, b}, 5'd0);
          state = ST_VOICE_BODY;
        end else begin
          voice_len = 6'd0;
          state     = ST_IDLE;
        end
      end
      ST_VOICE_BODY: begin
        queue_word(mfusp_pkg::KIND_HOST, {8'h00, b}, 5'd0);
        voice_seen = voice_seen + 6'd1;
        if (voice_seen >= voice_len)
          state = ST_IDLE;
      end
      ST_TEXT: begin
        if (b == mfusp_pkg::CHAR_LF || b == mfusp_pkg::CHAR_CR) begin
          if (start_alive && line_len == mfusp_pkg::START_CMD_LEN) begin
            call_active = 1'b1;
            queue_word(mfusp_pkg::KIND_CALL, 16'd1, 5'(mfusp_pkg::CALL_FIELD_IDX));
          end else if (end_alive && line_len == mfusp_pkg::END_CMD_LEN) begin
            call_active = 1'b0;
            queue_word(mfusp_pkg::KIND_CALL, 16'd0, 5'(mfusp_pkg::CALL_FIELD_IDX));
            // echo of the end command plus line feed
            for (i = 0; i < mfusp_pkg::END_CMD_LEN; i++)
              queue_word(mfusp_pkg::KIND_HOST,
                         {8'h00, END_CMD[8*(mfusp_pkg::END_CMD_LEN-1-i) +: 8]}, 5'd0);
            queue_word(mfusp_pkg::KIND_HOST, {8'h00, mfusp_pkg::CHAR_LF}, 5'd0);
          end
          line_len = 7'd0;
          state    = ST_IDLE;
        end else if (line_len < LINE_KEEP) begin
          if (line_len >= mfusp_pkg::START_CMD_LEN ||
              START_CMD[8*(mfusp_pkg::START_CMD_LEN-1-line_len) +: 8] != b)
            start_alive = 1'b0;
          if (line_len >= mfusp_pkg::END_CMD_LEN ||
              END_CMD[8*(mfusp_pkg::END_CMD_LEN-1-line_len) +: 8] != b)
            end_alive = 1'b0;
          line_len = line_len + 7'd1;
        end
      end
      default: state = ST_IDLE;
    endcase
    // flag the final word caused by this byte
    if (expected_words.size() > before_count) begin
      w      = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
    end
  endtask

  // compare accepted result words, then predict from the accepted input word
  always @(posedge clk) begin
    if (!rst_n) begin
      state           = ST_IDLE;
      sensor_pos      = 6'd0;
      sensor_xor      = 8'h00;
      voice_len       = 6'd0;
      voice_seen      = 6'd0;
      line_len        = 7'd0;
      start_alive     = 1'b1;
      end_alive       = 1'b1;
      call_active     = 1'b0;
      error_count     = 0;
      checked_count   = 0;
      expected_words.delete();
      result_errors   <= 0;
      results_pending <= 0;
      results_checked <= 0;
    end else begin
      if (out_valid && out_ready) begin
        checked_count++;
        if (expected_words.size() == 0) begin
          $error("unexpected result word: kind %0d data 0x%04h field_index %0d last %0b",
                 out_kind, out_data, out_field_index, out_last);
          error_count++;
        end else begin
          seen_word = expected_words.pop_front();
          if (out_kind !== seen_word.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", seen_word.kind, out_kind);
            error_count++;
          end
          if (out_data !== seen_word.data) begin
            $error("data mismatch: expected 0x%04h, actual 0x%04h", seen_word.data, out_data);
            error_count++;
          end
          if (out_field_index !== seen_word.field_index) begin
            $error("field_index mismatch: expected %0d, actual %0d",
                   seen_word.field_index, out_field_index);
            error_count++;
          end
          if (out_last !== seen_word.last) begin
            $error("last mismatch: expected %0b, actual %0b", seen_word.last, out_last);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready)
        decode_byte(in_rx_byte);
      result_errors   <= error_count;
      results_pending <= expected_words.size();
      results_checked <= checked_count;
    end
  end

endmodule

### test/testbench.sv
// top of the parser test: clock, reset, byte stimulus, result stalls and verdict
module testbench;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_BYTES = 40;

  logic clk;
  logic rst_n;

  mfusp_in_if  in_if ();
  mfusp_out_if out_if ();

  int result_errors;
  int results_pending;
  int results_checked;

  int cycle_count   = 0;
  int hold_requests = 0;
  int holds_granted;
  int rx_mode;
  int rx_mode_left;
  int rx_hold_left;

  int burst_left    = 0;
  int bytes_sent    = 0;
  int sensor_frames = 0;
  int bad_checks    = 0;
  int voice_frames  = 0;
  int text_lines    = 0;

  multi_frame_uart_stream_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  mfusp_parse_checker parse_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_rx_byte      (in_if.rx_byte),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_kind        (out_if.kind),
    .out_data        (out_if.data),
    .out_field_index (out_if.field_index),
    .out_last        (out_if.last),
    .result_errors   (result_errors),
    .results_pending (results_pending),
    .results_checked (results_checked)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[multi_frame_uart_stream_parser] ERROR");
      $finish;
    end
  end

  // result receiver: stall pattern in modes of random length, plus requested long holds
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready  <= 1'b0;
      rx_mode       <= 0;
      rx_mode_left  <= 0;
      rx_hold_left  <= 0;
      holds_granted <= 0;
    end else if (rx_hold_left > 0) begin
      out_if.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (holds_granted != hold_requests) begin
      out_if.ready  <= 1'b0;
      rx_hold_left  <= LONG_HOLD;
      holds_granted <= holds_granted + 1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(16, 160);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= ($urandom_range(0, 4) == 0);
        default: out_if.ready <= (rx_mode_left % 3 != 0);
      endcase
    end
  end

  // offer one word and wait for its handshake, in bursts with random gaps
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  // stop offering until every predicted word has come out
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // sensor frame with good or corrupted check; edge pattern or random body
  task automatic send_sensor_frame(input bit good, input bit edge_fill);
    localparam logic [8*15-1:0] EDGE_BYTES = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h00,
                                              8'h7F, 8'hFF, 8'hAA, 8'hA5, 8'h24, 8'h0A,
                                              8'h0D, 8'h55, 8'h5A};
    logic [7:0] b;
    logic [7:0] check;
    int         i;
    check = 8'h00;
    send_byte(mfusp_pkg::SYNC_SENSOR_A);
    send_byte(mfusp_pkg::SYNC_SENSOR_B);
    for (i = 0; i < 31; i++) begin
      if (!edge_fill)
        b = 8'($urandom_range(0, 255));
      else if (i < 15)
        b = EDGE_BYTES[8*(14-i) +: 8];
      else
        b = (i % 2 == 0) ? 8'hFF : 8'h00;
      check = check ^ b;
      send_byte(b);
    end
    if (!good) begin
      check = check ^ (8'h01 << $urandom_range(0, 7));
      bad_checks++;
    end
    send_byte(check);
    sensor_frames++;
  endtask

  // voice frame: header, length word, body when the length is legal
  task automatic send_voice_frame(input logic [7:0] len);
    int i;
    send_byte(mfusp_pkg::SYNC_VOICE_A);
    send_byte(mfusp_pkg::SYNC_VOICE_B);
    send_byte(len);
    if (len >= 1 && len <= mfusp_pkg::VOICE_MAX_BYTES)
      for (i = 0; i < len; i++)
        send_byte(8'($urandom_range(0, 255)));
    voice_frames++;
  endtask

  task automatic send_text_line(input string s, input logic [7:0] eol);
    int i;
    for (i = 0; i < s.len(); i++)
      send_byte(s[i]);
    send_byte(eol);
    text_lines++;
  endtask

  // dollar plus random characters that are never a line end
  task automatic send_random_line(input int n);
    logic [7:0] b;
    int         i;
    send_byte(mfusp_pkg::CHAR_DOLLAR);
    for (i = 0; i < n; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == mfusp_pkg::CHAR_LF ||
                                                 b == mfusp_pkg::CHAR_CR);
      send_byte(b);
    end
    send_byte($urandom_range(0, 1) ? mfusp_pkg::CHAR_LF : mfusp_pkg::CHAR_CR);
    text_lines++;
  endtask

  // stimulus
  initial begin
    logic [7:0] b;
    string      cmd;
    string      start_line;
    string      end_line;
    int         i;
    int         k;
    int         n;
    int         rounds;
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    rst_n         = 1'b0;
    start_line    = {"$CALL", "_START"};
    end_line      = {"$CALL", "_END"};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sensor extremes and a dropped frame
    send_sensor_frame(1'b1, 1'b1);
    send_sensor_frame(1'b0, 1'b0);

    // directed: voice length extremes and illegal lengths
    send_voice_frame(8'd1);
    send_voice_frame(8'd60);
    send_voice_frame(8'd0);
    send_voice_frame(8'd61);
    send_voice_frame(8'd255);

    // directed: call commands, repeats, near misses, empty and overlong lines
    send_text_line(start_line, mfusp_pkg::CHAR_CR);
    send_text_line(start_line, mfusp_pkg::CHAR_LF);
    send_text_line(end_line, mfusp_pkg::CHAR_LF);
    send_text_line(end_line, mfusp_pkg::CHAR_CR);
    send_text_line(start_line.substr(0, 9), mfusp_pkg::CHAR_LF);
    send_text_line({end_line, "X"}, mfusp_pkg::CHAR_CR);
    send_text_line("$", mfusp_pkg::CHAR_LF);
    send_random_line(130);

    // directed: broken headers swallow the second byte, idle noise is ignored
    send_byte(mfusp_pkg::SYNC_SENSOR_A);
    send_byte(mfusp_pkg::SYNC_VOICE_A);
    send_byte(mfusp_pkg::SYNC_VOICE_B);
    send_byte(8'd3);
    send_byte(mfusp_pkg::SYNC_VOICE_A);
    send_byte(mfusp_pkg::SYNC_SENSOR_A);
    send_byte(mfusp_pkg::SYNC_SENSOR_B);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(mfusp_pkg::CHAR_LF);
    send_byte(mfusp_pkg::CHAR_CR);
    wait_for_drain();

    // random: mostly well-formed frames, some broken headers and noise
    rounds = 0;
    n = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < n) begin
      rounds++;
      // receiver holds off for a long stretch while a frame keeps coming
      if (rounds == 1) begin
        hold_requests <= hold_requests + 1;
        send_sensor_frame(1'b1, 1'b0);
        send_voice_frame(8'($urandom_range(1, 8)));
      end
      case ($urandom_range(0, 9))
        0, 1: send_sensor_frame($urandom_range(0, 5) != 0, 1'b0);
        2, 3: send_voice_frame(($urandom_range(0, 9) == 0) ? 8'd60 :
                               8'($urandom_range(1, 8)));
        4, 5, 6: begin
          cmd = $urandom_range(0, 1) ? start_line : end_line;
          case ($urandom_range(0, 5))
            0, 1:    send_text_line(cmd, $urandom_range(0, 1) ? mfusp_pkg::CHAR_LF :
                                                                mfusp_pkg::CHAR_CR);
            2:       send_text_line(cmd.substr(0, $urandom_range(0, cmd.len() - 2)),
                                    mfusp_pkg::CHAR_LF);
            3:       send_text_line({cmd, "_"}, mfusp_pkg::CHAR_CR);
            4:       send_random_line($urandom_range(0, 12));
            default: send_random_line(($urandom_range(0, 3) == 0) ? $urandom_range(120, 140)
                                                                : $urandom_range(0, 6));
          endcase
        end
        7: begin
          // broken sequences
          case ($urandom_range(0, 2))
            0: begin
              send_byte(mfusp_pkg::SYNC_SENSOR_A);
              do b = 8'($urandom_range(0, 255)); while (b == mfusp_pkg::SYNC_SENSOR_B);
              send_byte(b);
            end
            1: begin
              send_byte(mfusp_pkg::SYNC_VOICE_A);
              do b = 8'($urandom_range(0, 255)); while (b == mfusp_pkg::SYNC_VOICE_B);
              send_byte(b);
            end
            default: send_voice_frame($urandom_range(0, 1) ? 8'd0 :
                                      8'($urandom_range(61, 255)));
          endcase
        end
        default: begin
          // idle noise, no text starts
          k = $urandom_range(1, 4);
          for (i = 0; i < k; i++) begin
            do b = 8'($urandom_range(0, 255)); while (b == mfusp_pkg::CHAR_DOLLAR);
            send_byte(b);
          end
        end
      endcase
    end

    wait_for_drain();
    repeat (40) @(posedge clk);
    $display("covered %0d input bytes: %0d sensor frames (%0d with a bad check),",
             bytes_sent, sensor_frames, bad_checks);
    $display("%0d voice frames, %0d text lines; compared %0d result words, %0d mismatches",
             voice_frames, text_lines, results_checked, result_errors);
    if (result_errors == 0 && results_pending == 0)
      $display("[multi_frame_uart_stream_parser] OK");
    else
      $display("[multi_frame_uart_stream_parser] ERROR");
    $finish;
  end

endmodule
